// ===== rtl/sfe_pkg.sv =====
// Shared constants, types and helpers of the series function evaluator.
// Depends on nothing; every rtl file imports it.
package sfe_pkg;

  // Series length limit and derived counter width
  localparam int MAX_TERMS = 128;
  localparam int N_W       = $clog2(MAX_TERMS + 1);
  // Width of the per-term divisor (2n)(2n+1)
  localparam int K_W       = 2 * N_W + 2;

  // Magnitudes of terms are capped at 2^56, so 57 bits hold them
  localparam int MAG_W     = 57;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int MUL_PARTS = 4;
  localparam int MUL_PH_W  = $clog2(MUL_PARTS + 1);

  // Divider: 64-bit dividend, 32-bit divisor, four quotient bits a cycle
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 32;
  localparam int RADIX_BITS = 4;
  localparam int DIV_STEPS  = NUM_W / RADIX_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [MAG_W-1:0]  TERM_CAP = MAG_W'(64'h0100_0000_0000_0000);
  localparam logic [MAG_W-1:0]  ONE_MAG  = MAG_W'(64'h0000_0001_0000_0000);
  localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] SUM_CAP   = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] SUM_FLOOR = 64'shC000_0000_0000_0000;
  localparam logic signed [63:0] RES_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] RES_MIN   = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    CMD_SIN = 2'd0,
    CMD_COS = 2'd1,
    CMD_EXP = 2'd2,
    CMD_LN  = 2'd3
  } cmd_t;

  // Clip a 64-bit magnitude to the term cap
  function automatic logic [MAG_W-1:0] cap_mag(input logic [63:0] v);
    logic [MAG_W-1:0] r;
    if (v > 64'(TERM_CAP)) begin
      r = TERM_CAP;
    end else begin
      r = v[MAG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sfe_mul.sv =====
// Iterative Q.32 magnitude multiplier: one 32x32 partial product per cycle,
// rounded half up and capped at the term limit. Depends on sfe_pkg.
module sfe_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sfe_pkg::MAG_W-1:0] a,
  input  logic [sfe_pkg::MAG_W-1:0] b,
  output logic                      done,
  output logic [sfe_pkg::MAG_W-1:0] p
);
  import sfe_pkg::*;

  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << 31;

  logic [MAG_W-1:0]    a_r, b_r;
  logic [PROD_W-1:0]   acc_r;
  logic [PROD_W-1:0]   pp_ext;
  logic [63:0]         pp_r;
  logic [1:0]          pos_r;
  logic [MUL_PH_W-1:0] ph_r;
  logic                run_r, pv_r, done_r;
  logic [31:0]         a_sel, b_sel;

  assign a_sel = ph_r[0] ? 32'(a_r[MAG_W-1:32]) : a_r[31:0];
  assign b_sel = ph_r[1] ? 32'(b_r[MAG_W-1:32]) : b_r[31:0];

  always_comb begin
    case (pos_r)
      2'd0:    pp_ext = PROD_W'(pp_r);
      2'd1:    pp_ext = PROD_W'(pp_r) << 32;
      default: pp_ext = PROD_W'(pp_r) << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        pv_r   <= 1'b0;
        ph_r   <= '0;
        done_r <= 1'b0;
      end else if (run_r) begin
        pv_r   <= (ph_r < MUL_PH_W'(MUL_PARTS));
        ph_r   <= ph_r + MUL_PH_W'(1);
        run_r  <= (ph_r != MUL_PH_W'(MUL_PARTS));
        done_r <= (ph_r == MUL_PH_W'(MUL_PARTS));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= ROUND;
    end else if (run_r) begin
      if (ph_r < MUL_PH_W'(MUL_PARTS)) begin
        pp_r  <= 64'(a_sel) * 64'(b_sel);
        pos_r <= {1'b0, ph_r[0]} + {1'b0, ph_r[1]};
      end
      if (pv_r) begin
        acc_r <= acc_r + pp_ext;
      end
    end
  end

  // Product at or above 2^96 overflows the Q.32 word: cap it
  assign p    = (|acc_r[PROD_W-1:96]) ? TERM_CAP : cap_mag(acc_r[95:32]);
  assign done = done_r;

endmodule

// ===== rtl/sfe_div.sv =====
// Iterative unsigned restoring divider, four quotient bits per cycle.
// Depends on sfe_pkg.
module sfe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sfe_pkg::NUM_W-1:0] num,
  input  logic [sfe_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [sfe_pkg::NUM_W-1:0] q
);
  import sfe_pkg::*;

  logic [NUM_W-1:0]     n_r, n_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt, den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r, done_r;

  always_comb begin
    logic [DEN_W:0] t;
    n_nxt   = n_r;
    rem_nxt = rem_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t     = {rem_nxt, n_nxt[NUM_W-1]};
      n_nxt = {n_nxt[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        rem_nxt  = DEN_W'(t - {1'b0, den_r});
        n_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (run_r) begin
        cnt_r  <= cnt_r - DIV_CNT_W'(1);
        run_r  <= (cnt_r != '0);
        done_r <= (cnt_r == '0);
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign q    = n_r;
  assign done = done_r;

endmodule

// ===== rtl/series_function_evaluator.sv =====
// Top level of the series function evaluator: command sequencer, term and
// sum registers. Depends on sfe_pkg, sfe_mul and sfe_div.
//
// Evaluates sin, cos, exp or ln of a signed Q4.28 argument by summing
// term_count terms of a power series (atanh form for ln) and returns a
// saturated signed Q16.32 result. A command transfers at a rising edge with
// start high and busy low; busy then stays high until the result is shown.
// The result on out_result/out_domain_error is marked by out_valid for exactly
// one cycle; it cannot be held off, so capture it in that cycle. busy
// drops in the strobe cycle, so the next command may transfer right then.
// Each term after the first runs the iterative multiplier (four 32x32 partial
// products), then the radix-16 divider that divides by the term's integer
// factor, and is then added to the sum. Setup and finish come around the
// terms (ln also divides once to form t). ln of a non-positive argument
// skips the series and returns zero with domain_error.
// Write term_count through cfg_we/cfg_wdata only while the block is idle;
// 0 is taken as 1 and counts above the term limit as the limit.
module series_function_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_x,
  output logic               out_valid,
  output logic signed [47:0] out_result,
  output logic               out_domain_error,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import sfe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TDIV = 7'b0000010,
    S_SQ   = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]         term_count_r;
  logic               issued_r;
  logic               out_valid_r;
  logic signed [47:0] out_result_r;
  logic               out_domain_error_r;

  cmd_t               cmd_r;
  logic [31:0]        x_r;
  logic               xq_neg_r;
  logic [MAG_W-1:0]   xq_mag_r;
  logic [N_W-1:0]     nterms_r, n_r;
  logic               err_r;
  logic [MAG_W-1:0]   sq_r;
  logic               term_neg_r, prod_neg_r, add_neg_r;
  logic [MAG_W-1:0]   term_mag_r, prod_mag_r, add_mag_r;
  logic signed [63:0] sum_r;

  // Unit handshakes
  logic               mul_start, mul_done, div_start, div_done;
  logic [MAG_W-1:0]   mul_a, mul_b, mul_p;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [DEN_W-1:0]   div_den;

  logic [N_W-1:0]     nterms_in;
  logic               in_one_term, in_ln_bad;
  logic [32:0]        x_mag_in;
  logic               ln_neg;
  logic [31:0]        ln_un, ln_den;
  logic [NUM_W-1:0]   ln_num;
  logic [N_W:0]       a2, a2p1, a2m1;
  logic [K_W-1:0]     k;
  logic [MAG_W:0]     dbl;
  logic [MAG_W-1:0]   dmag;
  logic [MAG_W-1:0]   q_mag;
  logic signed [63:0] t_signed, add_signed, acc_sum, sum_sat, res_sat;

  function automatic logic signed [63:0] to_signed(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    logic signed [63:0] v;
    v = $signed(64'(mag));
    return neg ? -v : v;
  endfunction

  // Clamp the register to the legal term count
  always_comb begin
    if (term_count_r == 8'd0) begin
      nterms_in = N_W'(1);
    end else if (32'(term_count_r) > MAX_TERMS) begin
      nterms_in = N_W'(MAX_TERMS);
    end else begin
      nterms_in = N_W'(term_count_r);
    end
  end

  assign in_one_term = (nterms_in == N_W'(1));
  assign in_ln_bad   = in_x[31] || (in_x == 32'sd0);
  assign x_mag_in    = in_x[31] ? 33'(-{in_x[31], in_x}) : {1'b0, in_x};

  // t = (x-1)/(x+1): x is positive here, so plain unsigned arithmetic
  assign ln_neg = (x_r < 32'h1000_0000);
  assign ln_un  = ln_neg ? (32'h1000_0000 - x_r) : (x_r - 32'h1000_0000);
  assign ln_den = x_r + 32'h1000_0000;
  assign ln_num = {ln_un, 32'h0} + 64'(ln_den >> 1);

  // Integer factor of term n
  assign a2   = {n_r, 1'b0};
  assign a2p1 = {n_r, 1'b1};
  assign a2m1 = a2 - (N_W + 1)'(1);

  always_comb begin
    case (cmd_r)
      CMD_SIN: k = K_W'(a2) * K_W'(a2p1);
      CMD_COS: k = K_W'(a2m1) * K_W'(a2);
      CMD_EXP: k = K_W'(n_r);
      default: k = K_W'(a2p1);
    endcase
  end

  // ln divides twice the power; clip it to the cap first
  assign dbl  = {prod_mag_r, 1'b0};
  assign dmag = (cmd_r == CMD_LN) ?
                ((dbl > (MAG_W + 1)'(TERM_CAP)) ? TERM_CAP : dbl[MAG_W-1:0]) :
                prod_mag_r;

  // Unit operands follow the state; start fires once on state entry
  assign mul_start = ((state_r == S_SQ) || (state_r == S_MUL)) && !issued_r;
  assign div_start = ((state_r == S_TDIV) || (state_r == S_DIV)) && !issued_r;

  assign mul_a = (state_r == S_MUL) ? term_mag_r :
                 ((cmd_r == CMD_LN) ? term_mag_r : xq_mag_r);
  assign mul_b = (state_r == S_MUL) ? ((cmd_r == CMD_EXP) ? xq_mag_r : sq_r) :
                 ((cmd_r == CMD_LN) ? term_mag_r : xq_mag_r);

  assign div_num = (state_r == S_DIV) ? (64'(dmag) + 64'(k >> 1)) : ln_num;
  assign div_den = (state_r == S_DIV) ? DEN_W'(k) : ln_den;

  sfe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  sfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign q_mag      = cap_mag(div_q);
  assign t_signed   = to_signed(ln_neg, q_mag);
  assign add_signed = to_signed(add_neg_r, add_mag_r);
  assign acc_sum    = sum_r + add_signed;

  always_comb begin
    if (acc_sum > SUM_CAP) begin
      sum_sat = SUM_CAP;
    end else if (acc_sum < SUM_FLOOR) begin
      sum_sat = SUM_FLOOR;
    end else begin
      sum_sat = acc_sum;
    end
    if (sum_r > RES_MAX) begin
      res_sat = RES_MAX;
    end else if (sum_r < RES_MIN) begin
      res_sat = RES_MIN;
    end else begin
      res_sat = sum_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_SIN, CMD_COS: state_nxt = S_SQ;
            CMD_EXP:          state_nxt = in_one_term ? S_DONE : S_MUL;
            default:          state_nxt = in_ln_bad ? S_DONE : S_TDIV;
          endcase
        end
      end
      S_TDIV: begin
        if (div_done) state_nxt = S_SQ;
      end
      S_SQ: begin
        if (mul_done) state_nxt = (nterms_r == N_W'(1)) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = ((n_r + N_W'(1)) == nterms_r) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issued_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      term_count_r <= 8'd100;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end
      if (cfg_we) begin
        term_count_r <= cfg_wdata;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_r    <= cmd_t'(in_command);
          x_r      <= in_x;
          xq_neg_r <= in_x[31];
          xq_mag_r <= MAG_W'({x_mag_in, 4'b0});
          nterms_r <= nterms_in;
          n_r      <= N_W'(1);
          err_r    <= (cmd_t'(in_command) == CMD_LN) && in_ln_bad;
          if (cmd_t'(in_command) == CMD_EXP) begin
            term_neg_r <= 1'b0;
            term_mag_r <= ONE_MAG;
            sum_r      <= ONE_Q32;
          end
          if ((cmd_t'(in_command) == CMD_LN) && in_ln_bad) begin
            sum_r <= '0;
          end
        end
      end
      S_TDIV: begin
        // Hold t as the first power; first term is 2t
        if (div_done) begin
          term_neg_r <= ln_neg;
          term_mag_r <= q_mag;
          sum_r      <= t_signed + t_signed;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          sq_r <= mul_p;
          if (cmd_r == CMD_SIN) begin
            term_neg_r <= xq_neg_r;
            term_mag_r <= xq_mag_r;
            sum_r      <= $signed({{28{x_r[31]}}, x_r, 4'b0});
          end else if (cmd_r == CMD_COS) begin
            term_neg_r <= 1'b0;
            term_mag_r <= ONE_MAG;
            sum_r      <= ONE_Q32;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          prod_neg_r <= term_neg_r ^ ((cmd_r == CMD_EXP) && xq_neg_r);
          prod_mag_r <= mul_p;
        end
      end
      S_DIV: begin
        if (div_done) begin
          add_mag_r <= q_mag;
          if (cmd_r == CMD_LN) begin
            // Keep the raw power for the next product
            add_neg_r  <= prod_neg_r;
            term_neg_r <= prod_neg_r;
            term_mag_r <= prod_mag_r;
          end else if (cmd_r == CMD_EXP) begin
            add_neg_r  <= prod_neg_r;
            term_neg_r <= prod_neg_r;
            term_mag_r <= q_mag;
          end else begin
            // Trig series alternate in sign
            add_neg_r  <= !prod_neg_r;
            term_neg_r <= !prod_neg_r;
            term_mag_r <= q_mag;
          end
        end
      end
      S_ACC: begin
        sum_r <= sum_sat;
        n_r   <= n_r + N_W'(1);
      end
      S_DONE: begin
        out_result_r       <= res_sat[47:0];
        out_domain_error_r <= err_r;
      end
      default: begin
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_domain_error = out_domain_error_r;

endmodule

// ===== tb/series_function_evaluator_tb.sv =====
// Self-checking testbench for series_function_evaluator: directed and random
// commands, with a bit-exact fixed-point predictor of every series result.
// Depends on sfe_pkg (command codes, term limit) and the evaluator RTL.
module series_function_evaluator_tb;
  import sfe_pkg::*;

  // Clock and watchdog
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  // Worst transfer-to-transfer gap: a 128-term series plus the longest
  // sender gap, taken several times over.
  localparam int STALL_LIMIT   = 20000;
  // Quiet cycles after the last expected result before a write or the end
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 1475;

  // Fixed-point constants of the series arithmetic
  localparam longint      Q32_ONE = 64'sh0000_0001_0000_0000;
  localparam longint      Q28_ONE = 64'sh0000_0000_1000_0000;
  localparam logic [63:0] MAG_CAP = 64'h0100_0000_0000_0000;
  localparam longint      ACC_CAP = 64'sh4000_0000_0000_0000;
  localparam longint      OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      OUT_MIN = 64'shFFFF_8000_0000_0000;

  // Argument corners, Q4.28
  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] X_ONE = 32'sh1000_0000;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] x;
    logic signed [47:0] value;
    logic               dom_err;
  } series_out_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  cmd_t               in_command;
  logic signed [31:0] in_x;
  logic               out_valid;
  logic signed [47:0] out_result;
  logic               out_domain_error;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;

  // Model copy of the term_count register
  logic [7:0]  series_len = 8'd100;
  series_out_t pending_results[$];
  int          error_count   = 0;
  int          transfers_in  = 0;
  int          cmd_seen[4]   = '{default: 0};
  int          domain_errors = 0;
  int          settings_used = 0;
  int          stall_cycles  = 0;

  series_function_evaluator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_x             (in_x),
    .out_valid        (out_valid),
    .out_result       (out_result),
    .out_domain_error (out_domain_error),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Clip a magnitude to the term cap and attach the sign
  function automatic longint with_sign(input logic [63:0] m, input bit neg);
    if (m > MAG_CAP) begin
      m = MAG_CAP;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q.32 product, magnitude rounded half away from zero
  function automatic longint q32_mul(input longint a, input longint b);
    logic [127:0] prod;
    logic [127:0] shifted;
    logic [63:0]  m;
    prod    = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    shifted = (prod + (128'd1 << 31)) >> 32;
    m       = (shifted[127:64] != 0) ? MAG_CAP : shifted[63:0];
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  // Division by a positive integer, magnitude rounded half away from zero
  function automatic longint q32_div(input longint a, input logic [63:0] k);
    logic [63:0] ua;
    ua = magnitude(a);
    if (k == 0) begin
      k = 1;
    end
    if (ua > MAG_CAP) begin
      ua = MAG_CAP;
    end
    return with_sign((ua + (k >> 1)) / k, a < 0);
  endfunction

  function automatic longint clamp_sum(input longint s, input longint t);
    longint r;
    r = s + t;
    if (r > ACC_CAP) begin
      r = ACC_CAP;
    end
    if (r < -ACC_CAP) begin
      r = -ACC_CAP;
    end
    return r;
  endfunction

  // Sum term_count terms of the selected series for one command
  function automatic series_out_t eval_series(input cmd_t cmd, input logic signed [31:0] x,
                                              input logic [7:0] len_reg);
    series_out_t r;
    longint      arg;
    longint      term;
    longint      sum;
    longint      sq;
    longint      p;
    longint      num;
    logic [63:0] den;
    logic [63:0] divisor;
    int          nterms;
    int          n;
    r.cmd     = cmd;
    r.x       = x;
    r.dom_err = 1'b0;
    // Zero counts as one term; anything past the limit is the limit
    nterms = (len_reg == 0) ? 1 : ((len_reg > MAX_TERMS) ? MAX_TERMS : int'(len_reg));
    arg    = longint'(x) * 16;
    sum    = 0;
    case (cmd)
      CMD_SIN, CMD_COS: begin
        sq   = q32_mul(arg, arg);
        term = (cmd == CMD_SIN) ? arg : Q32_ONE;
        sum  = term;
        for (n = 1; n < nterms; n++) begin
          divisor = (cmd == CMD_SIN) ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
          term    = -q32_div(q32_mul(term, sq), divisor);
          sum     = clamp_sum(sum, term);
        end
      end
      CMD_EXP: begin
        term = Q32_ONE;
        sum  = term;
        for (n = 1; n < nterms; n++) begin
          term = q32_div(q32_mul(term, arg), 64'(n));
          sum  = clamp_sum(sum, term);
        end
      end
      CMD_LN: begin
        if (x <= 0) begin
          // Outside the log domain: flag it and return zero
          r.dom_err = 1'b1;
        end else begin
          // atanh form: t = (x-1)/(x+1), ln x = 2 * sum t^(2k+1)/(2k+1)
          num = longint'(x) - Q28_ONE;
          den = 64'(longint'(x) + Q28_ONE);
          p   = with_sign(((magnitude(num) << 32) + (den >> 1)) / den, num < 0);
          sq  = q32_mul(p, p);
          sum = 2 * p;
          for (n = 1; n < nterms; n++) begin
            p   = q32_mul(p, sq);
            sum = clamp_sum(sum, q32_div(2 * p, 64'(2 * n + 1)));
          end
        end
      end
    endcase
    if (sum > OUT_MAX) begin
      sum = OUT_MAX;
    end
    if (sum < OUT_MIN) begin
      sum = OUT_MIN;
    end
    r.value = sum[47:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: predict on each command transfer, check each result transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : predict_commands
    series_out_t predicted;
    if (rst_n && start && !busy) begin
      predicted = eval_series(in_command, in_x, series_len);
      pending_results.push_back(predicted);
      transfers_in++;
      cmd_seen[in_command]++;
      if (predicted.dom_err) begin
        domain_errors++;
      end
    end
  end

  always @(posedge clk) begin : check_results
    series_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: result=%0d domain_error=%0b",
               out_result, out_domain_error);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result !== want.value) begin
          $error("result mismatch (cmd %0d, x=%h): expected %0d, actual %0d",
                 want.cmd, want.x, want.value, out_result);
          error_count++;
        end
        if (out_domain_error !== want.dom_err) begin
          $error("domain_error mismatch (cmd %0d, x=%h): expected %0b, actual %0b",
                 want.cmd, want.x, want.dom_err, out_domain_error);
          error_count++;
        end
      end
    end
  end

  // Abort when no transfer of either kind happens for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  // Present one command and hold it until it transfers. The caller must act
  // at the next falling edge (next command, gap or drain) to drop start.
  task automatic send_command(input cmd_t cmd, input logic signed [31:0] x, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      = 1'b1;
    in_command = cmd;
    in_x       = x;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for every outstanding result, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write term_count while idle and advance the model copy with it
  task automatic set_series_len(input logic [7:0] len);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we     = 1'b0;
    series_len = len;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run each function once at the reset term count, no register write first
  task automatic test_reset_count();
    send_command(CMD_SIN, X_ONE, 1'b0);
    send_command(CMD_COS, -(X_ONE >>> 1), 1'b0);
    send_command(CMD_EXP, X_ONE, 1'b0);
    send_command(CMD_LN, X_ONE <<< 1, 1'b1);
  endtask

  // Argument extremes for every function at the longest series, plus the
  // log domain edge and log of exactly one
  task automatic test_extremes();
    int c;
    set_series_len(8'd128);
    for (c = 0; c < 4; c++) begin
      send_command(cmd_t'(c), X_MIN, 1'b0);
      send_command(cmd_t'(c), X_MAX, 1'b0);
      send_command(cmd_t'(c), 32'sd0, 1'b0);
    end
    send_command(CMD_LN, -X_ONE, 1'b0);
    send_command(CMD_LN, 32'sd1, 1'b0);
    send_command(CMD_LN, X_ONE, 1'b0);
  endtask

  // Term counts of zero (taken as one), beyond the limit, and one
  task automatic test_count_limits();
    set_series_len(8'd0);
    send_command(CMD_SIN, X_ONE, 1'b0);
    send_command(CMD_EXP, -X_ONE, 1'b1);
    set_series_len(8'd255);
    send_command(CMD_COS, X_ONE <<< 1, 1'b0);
    send_command(CMD_LN, X_ONE >>> 1, 1'b0);
    set_series_len(8'd1);
    send_command(CMD_EXP, X_MAX, 1'b0);
    send_command(CMD_LN, 3 * X_ONE, 1'b1);
  endtask

  // Random phases: pick a term count, then a burst of random commands.
  // Keep most counts small so long series stay rare.
  task automatic test_random_mix(input int items);
    int                 target;
    int                 burst;
    int                 pick;
    int                 i;
    bit                 steady;
    logic [7:0]         len;
    cmd_t               cmd;
    logic signed [31:0] x;
    target = transfers_in + items;
    while (transfers_in < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0: len = 8'd100;
          1: len = 8'd128;
          2: len = 8'd200;
          default: len = 8'd255;
        endcase
        burst = $urandom_range(2, 4);
      end else if (pick < 5) begin
        len   = 8'($urandom_range(13, 40));
        burst = $urandom_range(8, 20);
      end else begin
        len   = 8'($urandom_range(0, 12));
        burst = $urandom_range(20, 60);
      end
      set_series_len(len);
      // One phase in four runs without any sender gaps
      steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < burst; i++) begin
        cmd = cmd_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1, 2: x = $urandom();
          3, 4, 5: x = 32'($urandom_range(0, 32'h2000_0000)) - X_ONE;
          6, 7:    x = 32'($urandom_range(1, 32'h7FFF_FFFF));
          8:       x = X_ONE + 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
          default: begin
            case ($urandom_range(0, 4))
              0: x = X_MIN;
              1: x = X_MAX;
              2: x = 32'sd0;
              3: x = -32'sd1;
              default: x = 32'sd1;
            endcase
          end
        endcase
        // Keep most log arguments inside the domain
        if (cmd == CMD_LN && $urandom_range(0, 3) != 0) begin
          x[31] = 1'b0;
        end
        send_command(cmd, x, steady);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_SIN;
    in_x       = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_count();
    test_extremes();
    test_count_limits();
    test_random_mix(RANDOM_ITEMS);
    drain_results();

    $display("Checked %0d commands: sin %0d, cos %0d, exp %0d, ln %0d (%0d log domain errors)",
             transfers_in, cmd_seen[CMD_SIN], cmd_seen[CMD_COS], cmd_seen[CMD_EXP],
             cmd_seen[CMD_LN], domain_errors);
    $display("Term count reprogrammed %0d times, including 0, 1, 128 and 255", settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
